/* src/atevp_pkg.sv */
package atevp_pkg;

    // Line and payload capacities
    localparam int LINE_MAX    = 256;
    localparam int PAYLOAD_MAX = 64;
    localparam int LINE_CAP    = LINE_MAX - 1;
    localparam int PAY_CAP     = (PAYLOAD_MAX - 1 > 63) ? 63 : PAYLOAD_MAX - 1;
    localparam int LINE_W      = $clog2(LINE_MAX);
    localparam int PAY_W       = 6;
    localparam int PAY_AW      = (PAY_CAP > 1) ? $clog2(PAY_CAP) : 1;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Token matcher states beyond the shared prefix
    localparam logic [3:0] MS_PREFIX = 4'd7;
    localparam logic [3:0] MS_RXP    = 4'd8;
    localparam logic [3:0] MS_RXP2   = 4'd9;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take_byte;
        logic start_run;
        logic next_byte;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_newline;
        logic deliver;
        logic out_last;
    } sts_t;

    // Shared prefix "+EVT:RX", one character per matched position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h2B;
            3'd1:    ch = 8'h45;
            3'd2:    ch = 8'h56;
            3'd3:    ch = 8'h54;
            3'd4:    ch = 8'h3A;
            3'd5:    ch = 8'h52;
            3'd6:    ch = 8'h58;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

/* src/at_event_line_payload_parser_core.sv */
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    rx_byte
// result    out        out_valid/out_ready  payload_byte, payload_length, empty_res, last
// config    in         cfg_valid/cfg_ready  cfg_data (deliver enable)
//
// An ordinary byte is accepted whenever the block is idle; the line state and payload store update at once.
// A newline that closes a matched line starts a run of results, one per cycle while the
// receiver is ready, read from the payload store through its registered read port.
// No input transaction is taken while a run is in progress.
// Reset clears the line state and the deliver enable; the payload store is not cleared.
// The config port is always ready.
module at_event_line_payload_parser_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  payload_byte,
    output logic [atevp_pkg::PAY_W-1:0] payload_length,
    output logic                        empty_res,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import atevp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencing of input and result transactions
    atevp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Matcher, counters and payload store
    atevp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .empty_res      (empty_res),
        .last           (last)
    );

endmodule

/* src/atevp_ctrl.sv */
module atevp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  atevp_pkg::sts_t sts,
    output atevp_pkg::cmd_t cmd
);
    import atevp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.start_run = 1'b0;
        cmd.next_byte = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid;
                if (in_valid && sts.is_newline && sts.deliver)
                begin
                    cmd.start_run = 1'b1;
                    state_next    = ST_SEND;
                end
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_byte = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/atevp_dp.sv */
module atevp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic                        cfg_data,
    input  logic [7:0]                  rx_byte,
    input  atevp_pkg::cmd_t             cmd,
    output atevp_pkg::sts_t             sts,
    output logic [7:0]                  payload_byte,
    output logic [atevp_pkg::PAY_W-1:0] payload_length,
    output logic                        empty_res,
    output logic                        last
);
    import atevp_pkg::*;

    logic              enable_reg,  enable_next;
    logic [3:0]        match_reg,   match_next;
    logic              event_reg,   event_next;
    logic [LINE_W-1:0] line_cnt_reg, line_cnt_next;
    logic              zero_reg,    zero_next;
    logic [PAY_W-1:0]  pay_cnt_reg, pay_cnt_next;
    logic [PAY_W-1:0]  idx_reg,     idx_next;
    logic [PAY_W-1:0]  len_reg,     len_next;
    logic [7:0]        rd_data_reg;

    logic [7:0]        mem [PAY_CAP];
    logic              wr_en;
    logic              rd_en;
    logic [PAY_W-1:0]  rd_addr;
    logic [PAY_W-1:0]  idx_inc;
    logic [3:0]        match_adv;
    logic              event_adv;

    assign idx_inc = idx_reg + 1'b1;

    // Streaming token matcher for "+EVT:RXP2P" and "+EVT:RX_"
    always_comb
    begin
        match_adv = (rx_byte == CH_PLUS) ? 4'd1 : 4'd0;
        event_adv = event_reg;
        if (match_reg < MS_PREFIX)
        begin
            if (rx_byte == prefix_char(match_reg[2:0]))
            begin
                match_adv = match_reg + 4'd1;
            end
        end
        else if (match_reg == MS_PREFIX)
        begin
            if (rx_byte == CH_UNDER)
            begin
                event_adv = 1'b1;
            end
            else if (rx_byte == CH_P)
            begin
                match_adv = MS_RXP;
            end
        end
        else if (match_reg == MS_RXP)
        begin
            if (rx_byte == CH_TWO)
            begin
                match_adv = MS_RXP2;
            end
        end
        else
        begin
            if (rx_byte == CH_P)
            begin
                event_adv = 1'b1;
            end
        end
    end

    // Deliver enable, line state update for each accepted byte and the replay index
    always_comb
    begin
        enable_next   = enable_reg;
        match_next    = match_reg;
        event_next    = event_reg;
        line_cnt_next = line_cnt_reg;
        zero_next     = zero_reg;
        pay_cnt_next  = pay_cnt_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        wr_en         = 1'b0;
        if (cfg_valid)
        begin
            enable_next = cfg_data;
        end
        if (cmd.take_byte)
        begin
            if (rx_byte == CH_NL)
            begin
                match_next    = '0;
                event_next    = 1'b0;
                line_cnt_next = '0;
                zero_next     = 1'b0;
                pay_cnt_next  = '0;
                if (cmd.start_run)
                begin
                    len_next = pay_cnt_reg;
                    idx_next = '0;
                end
            end
            else if (rx_byte != CH_CR && line_cnt_reg < LINE_W'(LINE_CAP))
            begin
                line_cnt_next = line_cnt_reg + 1'b1;
                if (!zero_reg)
                begin
                    if (rx_byte == CH_NUL)
                    begin
                        zero_next = 1'b1;
                    end
                    else
                    begin
                        match_next = match_adv;
                        event_next = event_adv;
                        if (rx_byte == CH_COLON)
                        begin
                            pay_cnt_next = '0;
                        end
                        else if (pay_cnt_reg < PAY_W'(PAY_CAP))
                        begin
                            wr_en        = 1'b1;
                            pay_cnt_next = pay_cnt_reg + 1'b1;
                        end
                    end
                end
            end
        end
        if (cmd.next_byte)
        begin
            idx_next = idx_inc;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            match_reg    <= '0;
            event_reg    <= 1'b0;
            line_cnt_reg <= '0;
            zero_reg     <= 1'b0;
            pay_cnt_reg  <= '0;
            idx_reg      <= '0;
            len_reg      <= '0;
        end
        else
        begin
            enable_reg   <= enable_next;
            match_reg    <= match_next;
            event_reg    <= event_next;
            line_cnt_reg <= line_cnt_next;
            zero_reg     <= zero_next;
            pay_cnt_reg  <= pay_cnt_next;
            idx_reg      <= idx_next;
            len_reg      <= len_next;
        end
    end

    // Payload store: written while a line arrives, read back during the run
    assign rd_en   = cmd.start_run | cmd.next_byte;
    assign rd_addr = cmd.start_run ? '0 : idx_inc;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pay_cnt_reg[PAY_AW-1:0]] <= rx_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr[PAY_AW-1:0]];
        end
    end

    // Result fields and status
    assign empty_res      = (len_reg == '0);
    assign last           = empty_res || (idx_inc == len_reg);
    assign payload_byte   = empty_res ? 8'h00 : rd_data_reg;
    assign payload_length = len_reg;

    assign sts.is_newline = (rx_byte == CH_NL);
    assign sts.deliver    = event_reg & enable_reg;
    assign sts.out_last   = last;

endmodule

/* src/atevp_checker.sv */
module atevp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] payload_byte,
    input logic [5:0] payload_length,
    input logic       empty_res,
    input logic       last
);

    // A stalled result holds its payload byte and last flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(last))
        else $error("result changed while stalled");

    // An empty run is a single zero result
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_res |-> last && payload_byte == 8'h00 && payload_length == 6'd0)
        else $error("malformed empty result");

    // A non-empty run reports a non-zero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !empty_res |-> payload_length != 6'd0)
        else $error("zero length on a payload byte");

    // No input transaction is taken during a run
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready during a run");

    // A run continues without a gap until its last result
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && $stable(payload_length))
        else $error("run broken before its last result");

endmodule

bind at_event_line_payload_parser_core atevp_checker u_atevp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .empty_res      (empty_res),
    .last           (last)
);
